// ===== rtl/fpr_pkg.sv =====
package fpr_pkg;

    // Number of fine-tune values held by default
    localparam int FPR_FINE_COUNT = 4;

    // Register addresses on the bus
    localparam logic [7:0] FPR_REG_DUTY      = 8'h00;
    localparam logic [7:0] FPR_REG_FAN_LO    = 8'h10;
    localparam logic [7:0] FPR_REG_FAN_HI    = 8'h11;
    localparam logic [7:0] FPR_REG_VOLT_LO   = 8'h20;
    localparam logic [7:0] FPR_REG_VOLT_HI   = 8'h21;
    localparam logic [7:0] FPR_REG_TEMP_LO   = 8'h30;
    localparam logic [7:0] FPR_REG_TEMP_HI   = 8'h31;
    localparam logic [7:0] FPR_REG_FINE_BASE = 8'h40;
    localparam logic [7:0] FPR_REG_HW_VER    = 8'hFD;
    localparam logic [7:0] FPR_REG_SW_VER    = 8'hFE;
    localparam logic [7:0] FPR_REG_DEV_ADDR  = 8'hFF;

    // Byte returned for an unknown register
    localparam logic [7:0] FPR_UNKNOWN_BYTE  = 8'hFF;

    // Mask of the checked part of a fine-tune byte
    localparam logic [7:0] FPR_FINE_MASK     = 8'h7F;

    // Reset values
    localparam logic [7:0] FPR_DUTY_RESET     = 8'h64;
    localparam logic [7:0] FPR_DUTY_MIN_RESET = 8'd20;
    localparam logic [7:0] FPR_DUTY_MAX_RESET = 8'd100;
    localparam logic [6:0] FPR_FINE_LIM_RESET = 7'd20;
    localparam logic [7:0] FPR_HW_VER_RESET   = 8'd1;
    localparam logic [7:0] FPR_SW_VER_RESET   = 8'd1;
    localparam logic [6:0] FPR_DEV_ADDR_RESET = 7'h5C;

    // Configuration register indexes
    localparam logic [2:0] FPR_CFG_DUTY_MIN = 3'd0;
    localparam logic [2:0] FPR_CFG_DUTY_MAX = 3'd1;
    localparam logic [2:0] FPR_CFG_FINE_LIM = 3'd2;
    localparam logic [2:0] FPR_CFG_HW_VER   = 3'd3;
    localparam logic [2:0] FPR_CFG_SW_VER   = 3'd4;
    localparam logic [2:0] FPR_CFG_DEV_ADDR = 3'd5;

    typedef struct packed {
        logic [7:0]  target_reg;
        logic [7:0]  data_count;
        logic [7:0]  wdata0;
        logic [7:0]  wdata1;
        logic [7:0]  wdata2;
        logic [7:0]  wdata3;
        logic [15:0] fan_speed;
        logic [15:0] supply_voltage;
        logic [15:0] chip_temperature;
    } t_item;

    typedef struct packed {
        logic [2:0]  read_len;
        logic [7:0]  rbyte0;
        logic [7:0]  rbyte1;
        logic [7:0]  rbyte2;
        logic [7:0]  rbyte3;
        logic        duty_changed;
        logic [11:0] pwm_compare;
        logic [3:0]  fine_changed_mask;
        logic [7:0]  fine_out0;
        logic [7:0]  fine_out1;
        logic [7:0]  fine_out2;
        logic [7:0]  fine_out3;
    } t_result;

    typedef struct packed {
        logic [7:0] duty_min;
        logic [7:0] duty_max;
        logic [6:0] fine_limit;
        logic [7:0] hw_version;
        logic [7:0] sw_version;
        logic [6:0] device_address;
    } t_cfg;

    typedef struct packed {
        logic       duty_changed;
        logic [3:0] fine_mask;
    } t_wr_status;

    typedef struct packed {
        logic [2:0] read_len;
        logic [7:0] rbyte0;
        logic [7:0] rbyte1;
        logic [7:0] rbyte2;
        logic [7:0] rbyte3;
    } t_read_data;

endpackage

// ===== rtl/fpr_if.sv =====
interface fpr_item_if
    import fpr_pkg::*;
();
    logic  valid;
    logic  ready;
    t_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface fpr_result_if
    import fpr_pkg::*;
();
    logic    valid;
    logic    ready;
    t_result result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

interface fpr_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] idx;
    logic [7:0] data;

    modport source (output valid, output idx, output data, input ready);
    modport sink   (input valid, input idx, input data, output ready);
endinterface

// ===== rtl/fan_pmic_i2c_register_map_unit.sv =====
// Channel  | Direction | Payload                                   | Beat accepted when
// ---------+-----------+-------------------------------------------+---------------------
// i_in     | sink      | one finished bus transaction (t_item)     | valid && ready
// o_out    | source    | read bytes, change flags, state (t_result)| valid && ready
// i_cfg    | sink      | register index and write byte             | valid && ready
//
// One transaction a cycle while the result side does not stall: a beat lands in
// the input register, the decode and update logic works on it combinationally,
// and the result register takes the answer.
// Reset (synchronous, active low) empties both registers, loads duty 100, clears the
// fine values and restores the configuration defaults.
// A stalled result holds the result register; the input register still takes a beat
// while it is empty, then the input side stalls too. Configuration is always ready.
module fan_pmic_i2c_register_map_unit
    import fpr_pkg::*;
#(
    parameter int FINE_COUNT = FPR_FINE_COUNT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fpr_item_if.sink      i_in,
    fpr_result_if.source  o_out,
    fpr_cfg_if.sink       i_cfg
);

    logic                     r_in_valid;
    t_item                    r_in;
    logic                     r_out_valid;
    t_result                  r_out;
    logic                     advance;
    t_cfg                     cfg;
    logic [7:0]               duty;
    logic [7:0]               next_duty;
    logic [FINE_COUNT*8-1:0]  fine_flat;
    logic [FINE_COUNT*8-1:0]  next_fine_flat;
    t_wr_status               status;
    t_read_data               rd;
    logic [7:0]               fine_vis [4];
    t_result                  n_out;

    // Move the held transaction on when the result register is free or draining
    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign o_out.valid = r_out_valid;
    assign o_out.result = r_out;

    fpr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    fpr_state #(
        .FINE_COUNT (FINE_COUNT)
    ) u_state (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item           (r_in),
        .i_advance        (advance),
        .i_cfg            (cfg),
        .o_duty           (duty),
        .o_fine_flat      (fine_flat),
        .o_next_duty      (next_duty),
        .o_next_fine_flat (next_fine_flat),
        .o_status         (status)
    );

    fpr_read_mux #(
        .FINE_COUNT (FINE_COUNT)
    ) u_read (
        .i_item      (r_in),
        .i_cfg       (cfg),
        .i_duty      (duty),
        .i_fine_flat (fine_flat),
        .o_rd        (rd)
    );

    // Fine values past the end of the bank read as zero
    for (genvar g = 0; g < 4; g++) begin : g_vis
        if (g < FINE_COUNT) begin : g_have
            assign fine_vis[g] = next_fine_flat[g*8 +: 8];
        end else begin : g_none
            assign fine_vis[g] = 8'd0;
        end
    end

    // Report state as it stands after this transaction
    always_comb begin
        n_out.read_len          = rd.read_len;
        n_out.rbyte0            = rd.rbyte0;
        n_out.rbyte1            = rd.rbyte1;
        n_out.rbyte2            = rd.rbyte2;
        n_out.rbyte3            = rd.rbyte3;
        n_out.duty_changed      = status.duty_changed;
        n_out.pwm_compare       = {next_duty, 4'b0000};
        n_out.fine_changed_mask = status.fine_mask;
        n_out.fine_out0         = fine_vis[0];
        n_out.fine_out1         = fine_vis[1];
        n_out.fine_out2         = fine_vis[2];
        n_out.fine_out3         = fine_vis[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in <= i_in.item;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== rtl/fpr_cfg_regs.sv =====
module fpr_cfg_regs
    import fpr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    fpr_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.duty_min       <= FPR_DUTY_MIN_RESET;
            r_cfg.duty_max       <= FPR_DUTY_MAX_RESET;
            r_cfg.fine_limit     <= FPR_FINE_LIM_RESET;
            r_cfg.hw_version     <= FPR_HW_VER_RESET;
            r_cfg.sw_version     <= FPR_SW_VER_RESET;
            r_cfg.device_address <= FPR_DEV_ADDR_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.idx)
                FPR_CFG_DUTY_MIN: r_cfg.duty_min       <= i_cfg.data;
                FPR_CFG_DUTY_MAX: r_cfg.duty_max       <= i_cfg.data;
                FPR_CFG_FINE_LIM: r_cfg.fine_limit     <= i_cfg.data[6:0];
                FPR_CFG_HW_VER:   r_cfg.hw_version     <= i_cfg.data;
                FPR_CFG_SW_VER:   r_cfg.sw_version     <= i_cfg.data;
                FPR_CFG_DEV_ADDR: r_cfg.device_address <= i_cfg.data[6:0];
                default: ; // drop writes to unused indexes
            endcase
        end
    end

endmodule

// ===== rtl/fpr_read_mux.sv =====
module fpr_read_mux
    import fpr_pkg::*;
#(
    parameter int FINE_COUNT = FPR_FINE_COUNT
) (
    input  t_item                    i_item,
    input  t_cfg                     i_cfg,
    input  logic [7:0]               i_duty,
    input  logic [FINE_COUNT*8-1:0]  i_fine_flat,
    output t_read_data               o_rd
);

    localparam int KW = (FINE_COUNT > 1) ? $clog2(FINE_COUNT) : 1;
    localparam int RW = (KW + 1 > 3) ? KW + 1 : 3;
    localparam int PW = FINE_COUNT * 8 + 32;

    logic          in_fine;
    logic [KW-1:0] k;
    logic [RW-1:0] rem;
    logic [PW-1:0] shifted;

    assign in_fine = (i_item.target_reg >= FPR_REG_FINE_BASE) &&
                     ({1'b0, i_item.target_reg} < 9'({1'b0, FPR_REG_FINE_BASE}) + 9'(FINE_COUNT));
    assign k       = i_item.target_reg[KW-1:0];
    assign rem     = RW'(FINE_COUNT) - RW'(k);
    // Bytes past the last fine value come out as zero from the padding
    assign shifted = {32'b0, i_fine_flat} >> {k, 3'b000};

    always_comb begin
        o_rd = '0;
        if (i_item.data_count == 8'd0) begin
            unique case (i_item.target_reg)
                FPR_REG_DUTY: begin
                    o_rd.read_len = 3'd1;
                    o_rd.rbyte0   = i_duty;
                end
                FPR_REG_DEV_ADDR: begin
                    o_rd.read_len = 3'd1;
                    o_rd.rbyte0   = {1'b0, i_cfg.device_address};
                end
                FPR_REG_HW_VER: begin
                    o_rd.read_len = 3'd2;
                    o_rd.rbyte0   = i_cfg.hw_version;
                    o_rd.rbyte1   = i_cfg.sw_version;
                end
                FPR_REG_SW_VER: begin
                    o_rd.read_len = 3'd1;
                    o_rd.rbyte0   = i_cfg.sw_version;
                end
                FPR_REG_FAN_LO: begin
                    o_rd.read_len = 3'd2;
                    o_rd.rbyte0   = i_item.fan_speed[7:0];
                    o_rd.rbyte1   = i_item.fan_speed[15:8];
                end
                FPR_REG_FAN_HI: begin
                    o_rd.read_len = 3'd1;
                    o_rd.rbyte0   = i_item.fan_speed[15:8];
                end
                FPR_REG_VOLT_LO: begin
                    o_rd.read_len = 3'd2;
                    o_rd.rbyte0   = i_item.supply_voltage[7:0];
                    o_rd.rbyte1   = i_item.supply_voltage[15:8];
                end
                FPR_REG_VOLT_HI: begin
                    o_rd.read_len = 3'd1;
                    o_rd.rbyte0   = i_item.supply_voltage[15:8];
                end
                FPR_REG_TEMP_LO: begin
                    o_rd.read_len = 3'd2;
                    o_rd.rbyte0   = i_item.chip_temperature[7:0];
                    o_rd.rbyte1   = i_item.chip_temperature[15:8];
                end
                FPR_REG_TEMP_HI: begin
                    o_rd.read_len = 3'd1;
                    o_rd.rbyte0   = i_item.chip_temperature[15:8];
                end
                default: begin
                    if (in_fine) begin
                        o_rd.read_len = (rem > RW'(4)) ? 3'd4 : rem[2:0];
                        o_rd.rbyte0   = shifted[7:0];
                        o_rd.rbyte1   = shifted[15:8];
                        o_rd.rbyte2   = shifted[23:16];
                        o_rd.rbyte3   = shifted[31:24];
                    end else begin
                        o_rd.read_len = 3'd1;
                        o_rd.rbyte0   = FPR_UNKNOWN_BYTE;
                    end
                end
            endcase
        end
    end

endmodule

// ===== rtl/fpr_state.sv =====
module fpr_state
    import fpr_pkg::*;
#(
    parameter int FINE_COUNT = FPR_FINE_COUNT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_item                    i_item,
    input  logic                     i_advance,
    input  t_cfg                     i_cfg,
    output logic [7:0]               o_duty,
    output logic [FINE_COUNT*8-1:0]  o_fine_flat,
    output logic [7:0]               o_next_duty,
    output logic [FINE_COUNT*8-1:0]  o_next_fine_flat,
    output t_wr_status               o_status
);

    localparam int KW = (FINE_COUNT > 1) ? $clog2(FINE_COUNT) : 1;

    logic [7:0]      r_duty;
    logic [7:0]      n_duty;
    logic [7:0]      r_fine [FINE_COUNT];
    logic [7:0]      n_fine [FINE_COUNT];
    logic [FINE_COUNT-1:0] fine_hit;
    logic [7:0]      wd [4];
    logic            is_write;
    logic            in_fine;
    logic            duty_hit;
    logic [KW-1:0]   k;

    assign wd[0]    = i_item.wdata0;
    assign wd[1]    = i_item.wdata1;
    assign wd[2]    = i_item.wdata2;
    assign wd[3]    = i_item.wdata3;
    assign is_write = (i_item.data_count != 8'd0);
    assign in_fine  = (i_item.target_reg >= FPR_REG_FINE_BASE) &&
                      ({1'b0, i_item.target_reg} < 9'({1'b0, FPR_REG_FINE_BASE}) + 9'(FINE_COUNT));
    assign k        = i_item.target_reg[KW-1:0];

    // Duty takes a single in-range byte that differs from the current value
    assign duty_hit = is_write && (i_item.target_reg == FPR_REG_DUTY) &&
                      (i_item.data_count == 8'd1) && (i_item.wdata0 != r_duty) &&
                      (i_item.wdata0 >= i_cfg.duty_min) && (i_item.wdata0 <= i_cfg.duty_max);
    assign n_duty   = duty_hit ? i_item.wdata0 : r_duty;

    for (genvar g = 0; g < FINE_COUNT; g++) begin : g_fine
        logic [KW:0] off;
        logic [7:0]  off8;
        logic [7:0]  v;

        assign off  = (KW+1)'(g) - {1'b0, k};
        assign off8 = 8'(off);
        assign v    = wd[off8[1:0]];
        assign fine_hit[g] = is_write && in_fine && ((KW+1)'(g) >= {1'b0, k}) &&
                             (off8 < 8'd4) && (off8 < i_item.data_count) &&
                             (v != r_fine[g]) && ((v & FPR_FINE_MASK) <= {1'b0, i_cfg.fine_limit});
        assign n_fine[g] = fine_hit[g] ? v : r_fine[g];
        assign o_fine_flat[g*8 +: 8]      = r_fine[g];
        assign o_next_fine_flat[g*8 +: 8] = n_fine[g];
    end

    always_comb begin
        o_status.duty_changed = duty_hit;
        o_status.fine_mask    = '0;
        for (int i = 0; i < 4; i++) begin
            if (i < FINE_COUNT) begin
                o_status.fine_mask[i] = fine_hit[i];
            end
        end
    end

    assign o_duty      = r_duty;
    assign o_next_duty = n_duty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty <= FPR_DUTY_RESET;
            for (int i = 0; i < FINE_COUNT; i++) begin
                r_fine[i] <= '0;
            end
        end else if (i_advance) begin
            r_duty <= n_duty;
            for (int i = 0; i < FINE_COUNT; i++) begin
                r_fine[i] <= n_fine[i];
            end
        end
    end

endmodule

// ===== rtl/fpr_checker.sv =====
module fpr_checker
    import fpr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_ready,
    input  t_result i_result
);

    // A stalled result beat stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result beat dropped while stalled");

    // Never more than four read bytes
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_result.read_len <= 3'd4))
        else $error("read length above four");

    // A write returns no read bytes
    a_write_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_result.read_len == 3'd0) |->
            (i_result.rbyte0 == 8'd0) && (i_result.rbyte1 == 8'd0) &&
            (i_result.rbyte2 == 8'd0) && (i_result.rbyte3 == 8'd0))
        else $error("read bytes on a write");

    // A read changes nothing
    a_read_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_result.read_len != 3'd0) |->
            !i_result.duty_changed && (i_result.fine_changed_mask == 4'd0))
        else $error("change flags set on a read");

    // PWM compare, the duty times sixteen, has its low four bits clear
    a_pwm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_result.pwm_compare[3:0] == 4'd0))
        else $error("PWM compare not a multiple of sixteen");

endmodule

bind fan_pmic_i2c_register_map_unit fpr_checker u_fpr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_out.valid),
    .i_ready  (o_out.ready),
    .i_result (o_out.result)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import fpr_pkg::*;

    // Input beat to result beat, in clock cycles
    localparam int RESULT_LATENCY = 2;
    // Cycles without any accepted beat before the run is abandoned
    localparam int STALL_LIMIT = 2000;
    // Beats per phase of random traffic
    localparam int PHASE_BEATS = 140;

    // Configuration indexes that map to no register: writes must change nothing
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    // Addresses that decode to nothing: a plain hole and one beside the fan word
    localparam logic [7:0] REG_UNMAPPED = 8'h55;
    localparam logic [7:0] REG_NEAR_FAN = 8'h12;

    // ------------------------------------------------------------------
    // Scoreboard: a bit-true copy of the register map plus the queue of
    // answers that the block still owes.
    // ------------------------------------------------------------------
    class regmap_scoreboard;
        logic [7:0] duty_min;
        logic [7:0] duty_max;
        logic [6:0] fine_lim;
        logic [7:0] hw_ver;
        logic [7:0] sw_ver;
        logic [6:0] dev_addr;
        logic [7:0] fan_duty;
        logic [7:0] fine_val [FPR_FINE_COUNT];
        t_result    owed_answers [$];
        int         errors;

        function new();
            duty_min = FPR_DUTY_MIN_RESET;
            duty_max = FPR_DUTY_MAX_RESET;
            fine_lim = FPR_FINE_LIM_RESET;
            hw_ver   = FPR_HW_VER_RESET;
            sw_ver   = FPR_SW_VER_RESET;
            dev_addr = FPR_DEV_ADDR_RESET;
            fan_duty = FPR_DUTY_RESET;
            foreach (fine_val[i]) fine_val[i] = 8'h00;
            errors = 0;
        endfunction

        function int pending();
            return owed_answers.size();
        endfunction

        function void set_reg(logic [2:0] idx, logic [7:0] data);
            case (idx)
                FPR_CFG_DUTY_MIN: duty_min = data;
                FPR_CFG_DUTY_MAX: duty_max = data;
                FPR_CFG_FINE_LIM: fine_lim = data[6:0];
                FPR_CFG_HW_VER:   hw_ver   = data;
                FPR_CFG_SW_VER:   sw_ver   = data;
                FPR_CFG_DEV_ADDR: dev_addr = data[6:0];
                default: ;
            endcase
        endfunction

        // Work out the answer to one accepted transaction and update the map
        function void note_item(t_item it);
            t_result     r;
            logic [7:0]  rb [4];
            logic [7:0]  wd [4];
            logic [15:0] word;
            logic [3:0]  mask;
            int          first;
            int          span;
            r    = '0;
            mask = 4'h0;
            foreach (rb[i]) rb[i] = 8'h00;
            wd[0] = it.wdata0;
            wd[1] = it.wdata1;
            wd[2] = it.wdata2;
            wd[3] = it.wdata3;

            // Sensor word picked by the high nibble of the address
            word = it.chip_temperature;
            if (it.target_reg[7:4] == FPR_REG_FAN_LO[7:4]) word = it.fan_speed;
            else if (it.target_reg[7:4] == FPR_REG_VOLT_LO[7:4]) word = it.supply_voltage;

            if (it.data_count == 8'd0) begin
                if (it.target_reg == FPR_REG_DUTY) begin
                    rb[0] = fan_duty;
                    r.read_len = 3'd1;
                end else if (it.target_reg == FPR_REG_DEV_ADDR) begin
                    rb[0] = {1'b0, dev_addr};
                    r.read_len = 3'd1;
                end else if (it.target_reg >= FPR_REG_FINE_BASE &&
                             it.target_reg < FPR_REG_FINE_BASE + FPR_FINE_COUNT) begin
                    first = it.target_reg - FPR_REG_FINE_BASE;
                    span  = FPR_FINE_COUNT - first;
                    if (span > 4) span = 4;
                    for (int i = 0; i < span; i++) rb[i] = fine_val[first + i];
                    r.read_len = 3'(span);
                end else if (it.target_reg == FPR_REG_HW_VER) begin
                    rb[0] = hw_ver;
                    rb[1] = sw_ver;
                    r.read_len = 3'd2;
                end else if (it.target_reg == FPR_REG_SW_VER) begin
                    rb[0] = sw_ver;
                    r.read_len = 3'd1;
                end else if (it.target_reg == FPR_REG_FAN_LO ||
                             it.target_reg == FPR_REG_VOLT_LO ||
                             it.target_reg == FPR_REG_TEMP_LO) begin
                    rb[0] = word[7:0];
                    rb[1] = word[15:8];
                    r.read_len = 3'd2;
                end else if (it.target_reg == FPR_REG_FAN_HI ||
                             it.target_reg == FPR_REG_VOLT_HI ||
                             it.target_reg == FPR_REG_TEMP_HI) begin
                    rb[0] = word[15:8];
                    r.read_len = 3'd1;
                end else begin
                    rb[0] = FPR_UNKNOWN_BYTE;
                    r.read_len = 3'd1;
                end
            end else if (it.target_reg == FPR_REG_DUTY) begin
                if (it.data_count == 8'd1 && it.wdata0 != fan_duty &&
                    it.wdata0 >= duty_min && it.wdata0 <= duty_max) begin
                    fan_duty = it.wdata0;
                    r.duty_changed = 1'b1;
                end
            end else if (it.target_reg >= FPR_REG_FINE_BASE &&
                         it.target_reg < FPR_REG_FINE_BASE + FPR_FINE_COUNT) begin
                first = it.target_reg - FPR_REG_FINE_BASE;
                span  = it.data_count;
                if (span > FPR_FINE_COUNT - first) span = FPR_FINE_COUNT - first;
                if (span > 4) span = 4;
                for (int i = 0; i < span; i++) begin
                    if (fine_val[first + i] != wd[i] && (wd[i] & FPR_FINE_MASK) <= fine_lim) begin
                        fine_val[first + i] = wd[i];
                        mask[first + i] = 1'b1;
                    end
                end
            end

            r.rbyte0            = rb[0];
            r.rbyte1            = rb[1];
            r.rbyte2            = rb[2];
            r.rbyte3            = rb[3];
            r.pwm_compare       = {fan_duty, 4'b0000};
            r.fine_changed_mask = mask;
            r.fine_out0         = fine_val[0];
            r.fine_out1         = fine_val[1];
            r.fine_out2         = fine_val[2];
            r.fine_out3         = fine_val[3];
            owed_answers.push_back(r);
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH %s", $time, msg);
            errors++;
        endtask

        task compare(string field, logic [15:0] got, logic [15:0] want);
            if (got !== want) report($sformatf("%s: got %h, want %h", field, got, want));
        endtask

        task check_result(t_result got);
            t_result want;
            if (owed_answers.size() == 0) begin
                report($sformatf("result beat with nothing owed: %h", got));
                return;
            end
            want = owed_answers.pop_front();
            compare("read_len", got.read_len, want.read_len);
            compare("rbyte0", got.rbyte0, want.rbyte0);
            compare("rbyte1", got.rbyte1, want.rbyte1);
            compare("rbyte2", got.rbyte2, want.rbyte2);
            compare("rbyte3", got.rbyte3, want.rbyte3);
            compare("duty_changed", got.duty_changed, want.duty_changed);
            compare("pwm_compare", got.pwm_compare, want.pwm_compare);
            compare("fine_changed_mask", got.fine_changed_mask, want.fine_changed_mask);
            compare("fine_out0", got.fine_out0, want.fine_out0);
            compare("fine_out1", got.fine_out1, want.fine_out1);
            compare("fine_out2", got.fine_out2, want.fine_out2);
            compare("fine_out3", got.fine_out3, want.fine_out3);
        endtask

        task flag_leftovers();
            if (owed_answers.size() != 0)
                report($sformatf("%0d results never arrived", owed_answers.size()));
        endtask
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n;

    fpr_item_if   in_if ();
    fpr_result_if out_if ();
    fpr_cfg_if    cfg_if ();

    regmap_scoreboard sb;

    fan_pmic_i2c_register_map_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly no gap, otherwise a random gap that now and then is a long hold
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 8);
        return $urandom_range(20, 50);
    endfunction

    // Transaction with random sensor words; callers override what they need
    function automatic t_item transaction(logic [7:0] addr, logic [7:0] cnt, logic [7:0] w0,
                                          logic [7:0] w1, logic [7:0] w2, logic [7:0] w3);
        t_item it;
        it.target_reg       = addr;
        it.data_count       = cnt;
        it.wdata0           = w0;
        it.wdata1           = w1;
        it.wdata2           = w2;
        it.wdata3           = w3;
        it.fan_speed        = 16'($urandom);
        it.supply_voltage   = 16'($urandom);
        it.chip_temperature = 16'($urandom);
        return it;
    endfunction

    // Duty byte inside the accepted window, just outside its edges, or at the current value
    function automatic logic [7:0] duty_candidate();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return sb.fan_duty;
        if (r < 7 && sb.duty_min <= sb.duty_max) return 8'($urandom_range(sb.duty_max, sb.duty_min));
        if (r < 8) return sb.duty_min - 8'd1;
        if (r < 9) return sb.duty_max + 8'd1;
        return 8'($urandom);
    endfunction

    // Fine byte around the limit, with a random top bit, sometimes unchanged
    function automatic logic [7:0] fine_candidate(int idx);
        int r;
        int top;
        r   = $urandom_range(0, 9);
        top = (sb.fine_lim == 7'h7F) ? 127 : sb.fine_lim + 1;
        if (r < 2 && idx < FPR_FINE_COUNT) return sb.fine_val[idx];
        if (r < 8) return {1'($urandom), 7'($urandom_range(top, 0))};
        return 8'($urandom);
    endfunction

    function automatic t_item random_transaction();
        t_item       it;
        int          pick;
        logic [7:0]  addr;
        logic [7:0]  cnt;
        logic [7:0]  wd [4];
        pick = $urandom_range(0, 99);
        if (pick < 30) addr = FPR_REG_DUTY;
        else if (pick < 60) addr = FPR_REG_FINE_BASE + 8'($urandom_range(0, FPR_FINE_COUNT - 1));
        else if (pick < 75) begin
            case ($urandom_range(0, 5))
                0: addr = FPR_REG_FAN_LO;
                1: addr = FPR_REG_FAN_HI;
                2: addr = FPR_REG_VOLT_LO;
                3: addr = FPR_REG_VOLT_HI;
                4: addr = FPR_REG_TEMP_LO;
                default: addr = FPR_REG_TEMP_HI;
            endcase
        end else if (pick < 85) begin
            case ($urandom_range(0, 2))
                0: addr = FPR_REG_HW_VER;
                1: addr = FPR_REG_SW_VER;
                default: addr = FPR_REG_DEV_ADDR;
            endcase
        end else addr = 8'($urandom);

        pick = $urandom_range(0, 99);
        if (pick < 40) cnt = 8'd0;
        else if (pick < 75) cnt = 8'd1;
        else if (pick < 90) cnt = 8'($urandom_range(2, 4));
        else if (pick < 95) cnt = 8'hFF;
        else cnt = 8'($urandom_range(5, 254));

        foreach (wd[i]) wd[i] = 8'($urandom);
        if (addr == FPR_REG_DUTY) wd[0] = duty_candidate();
        if (addr >= FPR_REG_FINE_BASE && addr < FPR_REG_FINE_BASE + FPR_FINE_COUNT)
            foreach (wd[i]) wd[i] = fine_candidate(addr - FPR_REG_FINE_BASE + i);
        it = transaction(addr, cnt, wd[0], wd[1], wd[2], wd[3]);
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Drop valid for the gap, then hold the beat until the block takes it
    task send_item(t_item it, int gap);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.item  <= it;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_item(it);
    endtask

    // Stop sending and wait for every owed answer, then let the pipe settle
    task hold_until_drained();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (RESULT_LATENCY + 1) @(posedge i_clk);
    endtask

    task write_reg(logic [2:0] idx, logic [7:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.idx   <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.set_reg(idx, data);
    endtask

    // Rewrite the whole register set; a spare index is poked on the way
    task program_regs(logic [7:0] lo, logic [7:0] hi, logic [7:0] lim,
                      logic [7:0] hw, logic [7:0] sw, logic [7:0] dev);
        write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 8'($urandom));
        write_reg(FPR_CFG_DUTY_MIN, lo);
        write_reg(FPR_CFG_DUTY_MAX, hi);
        write_reg(FPR_CFG_FINE_LIM, lim);
        write_reg(FPR_CFG_HW_VER, hw);
        write_reg(FPR_CFG_SW_VER, sw);
        write_reg(FPR_CFG_DEV_ADDR, dev);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task run_random(int count);
        bit calm;
        calm = 1'b0;
        for (int n = 0; n < count; n++) begin
            // Switch between back-to-back bursts and gappy traffic every 32 beats
            if (n % 32 == 0) calm = ($urandom_range(0, 2) == 0);
            // Occasionally let the block drain completely before going on
            if ($urandom_range(0, 99) == 0) hold_until_drained();
            send_item(random_transaction(), calm ? 0 : gap_len());
        end
    endtask

    // Directed pass under the reset configuration: every read target, the
    // limits of the duty window, wrong counts, fine writes cut at the end of
    // the row, the top-bit masking of fine bytes, and writes to dead addresses.
    task directed_items();
        t_item it;
        send_item(transaction(FPR_REG_DUTY, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00), 0);
        send_item(transaction(FPR_REG_DEV_ADDR, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 0);
        send_item(transaction(FPR_REG_HW_VER, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00), 1);
        send_item(transaction(FPR_REG_SW_VER, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00), 0);
        it = transaction(FPR_REG_FAN_LO, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        it.fan_speed = 16'hFFFF;
        send_item(it, 0);
        it = transaction(FPR_REG_FAN_HI, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        it.fan_speed = 16'h0000;
        send_item(it, 0);
        it = transaction(FPR_REG_VOLT_LO, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        it.supply_voltage = 16'h8001;
        send_item(it, 2);
        it = transaction(FPR_REG_VOLT_HI, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        it.supply_voltage = 16'h7FFE;
        send_item(it, 0);
        it = transaction(FPR_REG_TEMP_LO, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        it.chip_temperature = 16'hFFFF;
        send_item(it, 0);
        it = transaction(FPR_REG_TEMP_HI, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        it.chip_temperature = 16'h00FF;
        send_item(it, 0);
        send_item(transaction(REG_UNMAPPED, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00), 0);
        send_item(transaction(REG_NEAR_FAN, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00), 0);
        // Duty: same value, just below, just above, the low end, wrong counts, then the high end
        send_item(transaction(FPR_REG_DUTY, 8'd1, FPR_DUTY_RESET, 8'h00, 8'h00, 8'h00), 0);
        send_item(transaction(FPR_REG_DUTY, 8'd1, 8'd19, 8'h00, 8'h00, 8'h00), 0);
        send_item(transaction(FPR_REG_DUTY, 8'd1, 8'd101, 8'h00, 8'h00, 8'h00), 1);
        send_item(transaction(FPR_REG_DUTY, 8'd1, 8'd20, 8'h00, 8'h00, 8'h00), 0);
        send_item(transaction(FPR_REG_DUTY, 8'd2, 8'd50, 8'd50, 8'h00, 8'h00), 0);
        send_item(transaction(FPR_REG_DUTY, 8'hFF, 8'd100, 8'h00, 8'h00, 8'h00), 0);
        send_item(transaction(FPR_REG_DUTY, 8'd1, 8'd100, 8'h00, 8'h00, 8'h00), 0);
        // Fine: at limit, top bit set over a legal low part, over limit, unchanged
        send_item(transaction(FPR_REG_FINE_BASE, 8'd4, 8'd20, 8'h94, 8'd21, 8'h00), 0);
        send_item(transaction(FPR_REG_FINE_BASE + 8'd3, 8'hFF, 8'h8A, 8'd1, 8'd2, 8'd3), 0);
        send_item(transaction(FPR_REG_FINE_BASE + 8'd2, 8'd1, 8'h7F, 8'd5, 8'd5, 8'd5), 0);
        send_item(transaction(FPR_REG_FINE_BASE, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00), 0);
        send_item(transaction(FPR_REG_FINE_BASE + 8'd3, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00), 0);
        send_item(transaction(8'(FPR_REG_FINE_BASE + FPR_FINE_COUNT), 8'd2, 8'd1, 8'd1, 8'd1,
                              8'd1), 0);
        send_item(transaction(FPR_REG_DEV_ADDR, 8'd1, 8'd30, 8'd30, 8'd30, 8'd30), 0);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [7:0] lo;
        sb = new();
        in_if.valid  <= 1'b0;
        in_if.item   <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.idx   <= FPR_CFG_DUTY_MIN;
        cfg_if.data  <= 8'h00;
        i_rst_n      <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_items();
        run_random(PHASE_BEATS);

        // Widest window, largest limit, extreme version and address bytes
        hold_until_drained();
        program_regs(8'd0, 8'd255, 8'h7F, 8'h00, 8'hFF, 8'h7F);
        run_random(PHASE_BEATS);

        // Empty duty window, zero fine limit
        hold_until_drained();
        program_regs(8'd255, 8'd0, 8'h00, 8'hFF, 8'h00, 8'h00);
        run_random(PHASE_BEATS);

        // One-value window; top bits of the 7-bit registers must be dropped
        hold_until_drained();
        program_regs(8'd128, 8'd128, 8'h85, 8'hA5, 8'h5A, 8'hFF);
        run_random(PHASE_BEATS);

        // Random windows, limits and identity bytes
        for (int p = 0; p < 4; p++) begin
            hold_until_drained();
            lo = 8'($urandom_range(0, 200));
            program_regs(lo, lo + 8'($urandom_range(0, 55)), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom));
            run_random(PHASE_BEATS);
        end

        // Back to the reset settings
        hold_until_drained();
        program_regs(FPR_DUTY_MIN_RESET, FPR_DUTY_MAX_RESET, {1'b0, FPR_FINE_LIM_RESET},
                     FPR_HW_VER_RESET, FPR_SW_VER_RESET, {1'b0, FPR_DEV_ADDR_RESET});
        run_random(PHASE_BEATS);

        hold_until_drained();
        repeat (4 * RESULT_LATENCY) @(posedge i_clk);
        sb.flag_leftovers();
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: take beats, check them, and stall at random
    // ------------------------------------------------------------------
    initial begin : result_drain
        int stall_left;
        int tick;
        bit calm;
        stall_left = 0;
        tick       = 0;
        calm       = 1'b0;
        out_if.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (out_if.valid && out_if.ready) sb.check_result(out_if.result);
            tick++;
            // Swap between always-ready stretches and stalling ones
            if (tick % 64 == 0) calm = ($urandom_range(0, 2) == 0);
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0) stall_left = gap_len();
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: abandon the run after a long spell with no beat on any channel
    // ------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                (cfg_if.valid && cfg_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== fan_pmic_i2c_register_map_unit.f =====
rtl/fpr_pkg.sv
rtl/fpr_if.sv
rtl/fpr_cfg_regs.sv
rtl/fpr_read_mux.sv
rtl/fpr_state.sv
rtl/fan_pmic_i2c_register_map_unit.sv
rtl/fpr_checker.sv
tb/sv/tb_top.sv
